>>> hw/rtl/nptw_pkg.sv
// ----------------------------------------------------------------------------
// nptw_pkg
// Types, codes and helpers shared by the page-table walker modules.
// ----------------------------------------------------------------------------
package nptw_pkg;

	localparam int unsigned AddrW  = 52;
	localparam int unsigned PteW   = 64;
	localparam int unsigned FaultW = 33;

	typedef enum logic [1:0] {
		KIND_READ  = 2'd0,
		KIND_DONE  = 2'd1,
		KIND_FAULT = 2'd2
	} kind_t;

	localparam logic ACT_START = 1'b0;
	localparam logic ACT_RESP  = 1'b1;

	localparam logic [1:0] ACC_WRITE = 2'd1;
	localparam logic [1:0] ACC_EXEC  = 2'd2;

	localparam logic [2:0] LVL_1 = 3'd1;
	localparam logic [2:0] LVL_2 = 3'd2;
	localparam logic [2:0] LVL_3 = 3'd3;
	localparam logic [2:0] LVL_4 = 3'd4;

	localparam logic [2:0] R_READ  = 3'b001;
	localparam logic [2:0] R_WRITE = 3'b010;
	localparam logic [2:0] R_EXEC  = 3'b100;
	localparam logic [2:0] R_ALL   = 3'b111;

	localparam int unsigned PTE_V  = 0;
	localparam int unsigned PTE_RW = 1;
	localparam int unsigned PTE_U  = 2;
	localparam int unsigned PTE_PS = 7;
	localparam int unsigned PTE_NX = 63;

	typedef struct packed {
		logic             action;
		logic [AddrW-1:0] guest_addr;
		logic [1:0]       access_kind;
		logic [PteW-1:0]  read_data;
		logic             read_error;
	} item_t;

	typedef struct packed {
		logic             busy;
		logic [2:0]       level;
		logic [AddrW-1:0] base;
		logic [2:0]       rights;
		logic [AddrW-1:0] paddr;
		logic [1:0]       pacc;
	} walk_t;

	typedef struct packed {
		logic              valid;
		kind_t             kind;
		logic [AddrW-1:0]  read_address;
		logic [AddrW-1:0]  translated_addr;
		logic [2:0]        permissions;
		logic [FaultW-1:0] fault_info;
	} result_t;

	function automatic logic [2:0] access_mask(input logic [1:0] k);
		logic [2:0] m;
		case (k)
			ACC_WRITE: m = R_WRITE;
			ACC_EXEC:  m = R_EXEC;
			default:   m = R_READ;
		endcase
		return m;
	endfunction

	function automatic logic [AddrW-1:0] entry_addr(input logic [AddrW-1:0] base,
		input logic [AddrW-1:0] va, input logic [2:0] lvl);
		logic [8:0] idx;
		case (lvl)
			LVL_1:   idx = va[20:12];
			LVL_2:   idx = va[29:21];
			LVL_3:   idx = va[38:30];
			default: idx = va[47:39];
		endcase
		return {base[AddrW-1:12], idx, 3'b000};
	endfunction

	function automatic walk_t walk_idle();
		walk_t w;
		w.busy   = 1'b0;
		w.level  = LVL_4;
		w.base   = '0;
		w.rights = R_ALL;
		w.paddr  = '0;
		w.pacc   = '0;
		return w;
	endfunction

endpackage

>>> hw/rtl/nptw_step.sv
// ----------------------------------------------------------------------------
// nptw_step
// One walk step: start, or check of a returned entry, giving the next walk
// state and at most one result.
// ----------------------------------------------------------------------------
module nptw_step (
	input  nptw_pkg::item_t           item,
	input  nptw_pkg::walk_t           cur,
	input  logic [nptw_pkg::AddrW-1:0] root,
	output nptw_pkg::walk_t           nxt,
	output nptw_pkg::result_t         res
);

	logic [2:0]                 acc;
	logic [2:0]                 rights;
	logic                       bad_entry;
	logic                       big_page;
	logic                       last_level;
	logic [nptw_pkg::AddrW-1:0] frame;
	logic [nptw_pkg::AddrW-1:0] pte_base;
	logic                       denied;

	always_comb begin
		acc        = nptw_pkg::access_mask(cur.pacc);
		bad_entry  = item.read_error || !item.read_data[nptw_pkg::PTE_V] ||
			!item.read_data[nptw_pkg::PTE_U];
		rights     = cur.rights;
		if (!item.read_data[nptw_pkg::PTE_RW])
			rights = rights & ~nptw_pkg::R_WRITE;
		if (item.read_data[nptw_pkg::PTE_NX])
			rights = rights & ~nptw_pkg::R_EXEC;
		big_page   = item.read_data[nptw_pkg::PTE_PS] &&
			(cur.level == nptw_pkg::LVL_3 || cur.level == nptw_pkg::LVL_2);
		last_level = (cur.level <= nptw_pkg::LVL_1);
		pte_base   = {item.read_data[nptw_pkg::AddrW-1:12], 12'h000};
		if (big_page && cur.level == nptw_pkg::LVL_3)
			frame = {item.read_data[nptw_pkg::AddrW-1:30], cur.paddr[29:0]};
		else if (big_page)
			frame = {item.read_data[nptw_pkg::AddrW-1:21], cur.paddr[20:0]};
		else
			frame = {item.read_data[nptw_pkg::AddrW-1:12], cur.paddr[11:0]};
		denied     = (acc & rights) != acc;

		nxt                 = cur;
		res                 = '0;
		res.kind            = nptw_pkg::KIND_READ;

		if (item.action == nptw_pkg::ACT_START) begin
			nxt.busy         = 1'b1;
			nxt.level        = nptw_pkg::LVL_4;
			nxt.rights       = nptw_pkg::R_ALL;
			nxt.paddr        = item.guest_addr;
			nxt.pacc         = item.access_kind;
			nxt.base         = {root[nptw_pkg::AddrW-1:12], 12'h000};
			res.valid        = 1'b1;
			res.read_address = nptw_pkg::entry_addr(nxt.base, nxt.paddr, nxt.level);
		end else if (cur.busy) begin
			res.valid = 1'b1;
			if (bad_entry || ((big_page || last_level) && denied)) begin
				nxt             = nptw_pkg::walk_idle();
				res.kind        = nptw_pkg::KIND_FAULT;
				res.fault_info  = {1'b1, 27'd0, acc[2], 1'b0, 1'b1, acc[1],
					!bad_entry};
			end else if (big_page || last_level) begin
				nxt                 = nptw_pkg::walk_idle();
				res.kind            = nptw_pkg::KIND_DONE;
				res.translated_addr = frame;
				res.permissions     = rights;
			end else begin
				nxt.rights       = rights;
				nxt.base         = pte_base;
				nxt.level        = cur.level - 3'd1;
				res.read_address = nptw_pkg::entry_addr(pte_base, cur.paddr, nxt.level);
			end
		end
	end

endmodule

>>> hw/rtl/nested_page_table_walker_core.sv
// ----------------------------------------------------------------------------
// nested_page_table_walker_core
// Four-level page-table walker: table entry read requests, translations with
// permissions, and fault words.
// ----------------------------------------------------------------------------
// Takes one beat per cycle while no result waits in a stalled output register,
// start or entry response alike. The beat is registered, checked by the step
// logic against the walk state, and any result lands in the output register.
// The walk-state update through the step logic is combinational, so
// back-to-back beats run at one per cycle; a walk issues up to four entry reads.
module nested_page_table_walker_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [nptw_pkg::AddrW-1:0]        cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              action,
	input  logic [nptw_pkg::AddrW-1:0]        guest_addr,
	input  logic [1:0]                        access_kind,
	input  logic [nptw_pkg::PteW-1:0]         read_data,
	input  logic                              read_error,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [1:0]                        kind,
	output logic [nptw_pkg::AddrW-1:0]        read_address,
	output logic [nptw_pkg::AddrW-1:0]        translated_addr,
	output logic [2:0]                        permissions,
	output logic [nptw_pkg::FaultW-1:0]       fault_info
);

	logic [nptw_pkg::AddrW-1:0] root_q;
	nptw_pkg::item_t            item_s1;
	logic                       valid_s1;
	nptw_pkg::walk_t            walk_q;
	nptw_pkg::walk_t            walk_nxt;
	nptw_pkg::result_t          res;
	nptw_pkg::result_t          res_s2;
	logic                       valid_s2;
	logic                       adv;
	logic                       load_s1;

	nptw_step u_step (
		.item (item_s1),
		.cur  (walk_q),
		.root (root_q),
		.nxt  (walk_nxt),
		.res  (res)
	);

	assign adv      = valid_s1 && (!res.valid || !valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign load_s1  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q <= '0;
		end else if (cfg_we) begin
			root_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			item_s1.action      <= action;
			item_s1.guest_addr  <= guest_addr;
			item_s1.access_kind <= access_kind;
			item_s1.read_data   <= read_data;
			item_s1.read_error  <= read_error;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q <= nptw_pkg::walk_idle();
		end else if (adv) begin
			walk_q <= walk_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv && res.valid) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.valid) begin
			res_s2 <= res;
		end
	end

	assign out_valid       = valid_s2;
	assign kind            = res_s2.kind;
	assign read_address    = res_s2.read_address;
	assign translated_addr = res_s2.translated_addr;
	assign permissions     = res_s2.permissions;
	assign fault_info      = res_s2.fault_info;

	a_end_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res.valid && res.kind != nptw_pkg::KIND_READ |=> !walk_q.busy)
		else $error("walk still busy after translation or fault");

	a_read_keeps_busy: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res.valid && res.kind == nptw_pkg::KIND_READ |=> walk_q.busy)
		else $error("walk idle after read request");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		walk_q.busy |-> walk_q.level >= nptw_pkg::LVL_1 &&
			walk_q.level <= nptw_pkg::LVL_4)
		else $error("walk level out of range");

	a_done_clean: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.kind == nptw_pkg::KIND_DONE |->
			res_s2.fault_info == '0 && res_s2.read_address == '0 &&
			res_s2.permissions[0])
		else $error("translation beat carries stray fields");

	a_fault_marks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.kind == nptw_pkg::KIND_FAULT |->
			res_s2.fault_info[2] && res_s2.fault_info[32] &&
			res_s2.translated_addr == '0)
		else $error("fault word malformed");

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb: nested_page_table_walker_core testbench
// A short list of directed walks (extreme addresses, every access kind, large
// pages, bad entries, read errors, abandoned walks) runs first. Random walks
// follow, mostly well formed with random entry contents, mixed with stray
// responses and broken walks. Each phase uses its own root pointer and its own
// mix of sender gaps and receiver stalls. Each beat the walker accepts runs
// through a local model of the walk state. The walker's results are compared
// field by field, in order, against the expected results this produces.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] ACC_READ = 2'd0;
	localparam logic [1:0] ACC_RSVD = 2'd3;
	localparam int unsigned CYCLE_CAP = 300000;
	localparam int unsigned PHASE_BEATS = 460;
	localparam int unsigned SETTLE = 8;

	typedef struct packed {
		nptw_pkg::kind_t                      kind;
		logic [nptw_pkg::AddrW-1:0]  rd_addr;
		logic [nptw_pkg::AddrW-1:0]  xaddr;
		logic [2:0]                  perms;
		logic [nptw_pkg::FaultW-1:0] finfo;
	} xlat_t;

	typedef struct packed {
		nptw_pkg::item_t it;
		bit              chk;
		xlat_t           want;
	} row_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        cfg_we = 1'b0;
	logic [nptw_pkg::AddrW-1:0]  cfg_wdata = '0;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	logic                        action = nptw_pkg::ACT_START;
	logic [nptw_pkg::AddrW-1:0]  guest_addr = '0;
	logic [1:0]                  access_kind = ACC_READ;
	logic [nptw_pkg::PteW-1:0]   read_data = '0;
	logic                        read_error = 1'b0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic [1:0]                  kind;
	logic [nptw_pkg::AddrW-1:0]  read_address;
	logic [nptw_pkg::AddrW-1:0]  translated_addr;
	logic [2:0]                  permissions;
	logic [nptw_pkg::FaultW-1:0] fault_info;

	bit                          drv_chk = 1'b0;
	xlat_t                       drv_want = '0;

	// walk model state
	logic [nptw_pkg::AddrW-1:0]  root_reg = '0;
	logic                        wk_busy = 1'b0;
	logic [2:0]                  wk_lvl = nptw_pkg::LVL_4;
	logic [nptw_pkg::AddrW-1:0]  wk_base = '0;
	logic [2:0]                  wk_rights = nptw_pkg::R_ALL;
	logic [nptw_pkg::AddrW-1:0]  wk_paddr = '0;
	logic [1:0]                  wk_pacc = ACC_READ;

	xlat_t                       pending_results[$];
	row_t                        dir_rows[$];

	int unsigned                 tx_pct = 0;
	int unsigned                 rx_pct = 0;
	int unsigned                 cycles = 0;
	int unsigned                 errs = 0;
	int unsigned                 n_items = 0;
	int unsigned                 n_beats = 0;
	int unsigned                 n_results = 0;
	int unsigned                 n_done = 0;
	int unsigned                 n_fault = 0;
	bit                          walk_open = 1'b0;

	nested_page_table_walker_core DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.action          (action),
		.guest_addr      (guest_addr),
		.access_kind     (access_kind),
		.read_data       (read_data),
		.read_error      (read_error),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.kind            (kind),
		.read_address    (read_address),
		.translated_addr (translated_addr),
		.permissions     (permissions),
		.fault_info      (fault_info)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_CAP) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				pending_results.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic logic [2:0] needed_right(input logic [1:0] acc);
		case (acc)
			nptw_pkg::ACC_WRITE: return nptw_pkg::R_WRITE;
			nptw_pkg::ACC_EXEC:  return nptw_pkg::R_EXEC;
			default:             return nptw_pkg::R_READ;
		endcase
	endfunction

	function automatic void walk_reset();
		wk_busy   = 1'b0;
		wk_lvl    = nptw_pkg::LVL_4;
		wk_base   = '0;
		wk_rights = nptw_pkg::R_ALL;
		wk_paddr  = '0;
		wk_pacc   = ACC_READ;
	endfunction

	function automatic xlat_t entry_request();
		xlat_t r;
		logic [nptw_pkg::AddrW-1:0] sh;
		r = '0;
		sh = wk_paddr >> (12 + 9 * (int'(wk_lvl) - 1));
		r.kind = nptw_pkg::KIND_READ;
		r.rd_addr = wk_base + {40'd0, sh[8:0], 3'b000};
		return r;
	endfunction

	function automatic xlat_t fault_word(input logic present);
		xlat_t r;
		logic [2:0] need;
		r = '0;
		need = needed_right(wk_pacc);
		r.kind = nptw_pkg::KIND_FAULT;
		r.finfo = {1'b1, 27'd0, need[2], 1'b0, 1'b1, need[1], present};
		walk_reset();
		return r;
	endfunction

	// one accepted beat through the walk; returns 1 when it yields a result
	function automatic bit walk_step(input nptw_pkg::item_t b, output xlat_t r);
		logic [nptw_pkg::AddrW-1:0] frame, low;
		logic [2:0] need;
		r = '0;
		if (b.action == nptw_pkg::ACT_START) begin
			wk_busy   = 1'b1;
			wk_lvl    = nptw_pkg::LVL_4;
			wk_rights = nptw_pkg::R_ALL;
			wk_paddr  = b.guest_addr;
			wk_pacc   = b.access_kind;
			wk_base   = {root_reg[nptw_pkg::AddrW-1:12], 12'h000};
			r = entry_request();
			return 1'b1;
		end
		if (!wk_busy)
			return 1'b0;
		if (b.read_error || !b.read_data[nptw_pkg::PTE_V] ||
			!b.read_data[nptw_pkg::PTE_U]) begin
			r = fault_word(1'b0);
			return 1'b1;
		end
		if (!b.read_data[nptw_pkg::PTE_RW])
			wk_rights &= ~nptw_pkg::R_WRITE;
		if (b.read_data[nptw_pkg::PTE_NX])
			wk_rights &= ~nptw_pkg::R_EXEC;
		if ((wk_lvl == nptw_pkg::LVL_3 || wk_lvl == nptw_pkg::LVL_2) &&
			b.read_data[nptw_pkg::PTE_PS]) begin
			low = (52'd1 << (12 + 9 * (int'(wk_lvl) - 1))) - 52'd1;
			frame = (b.read_data[nptw_pkg::AddrW-1:0] & ~low) | (wk_paddr & low);
		end else if (wk_lvl == nptw_pkg::LVL_1) begin
			frame = {b.read_data[nptw_pkg::AddrW-1:12], wk_paddr[11:0]};
		end else begin
			wk_base = {b.read_data[nptw_pkg::AddrW-1:12], 12'h000};
			wk_lvl  = wk_lvl - 3'd1;
			r = entry_request();
			return 1'b1;
		end
		need = needed_right(wk_pacc);
		if ((need & wk_rights) != need) begin
			r = fault_word(1'b1);
			return 1'b1;
		end
		r.kind = nptw_pkg::KIND_DONE;
		r.xaddr = frame;
		r.perms = wk_rights;
		walk_reset();
		return 1'b1;
	endfunction

	always @(posedge clk) begin
		nptw_pkg::item_t b;
		xlat_t r;
		if (arst_n) begin
			if (cfg_we)
				root_reg = cfg_wdata;
			if (in_valid && !in_stall) begin
				n_beats++;
				b.action      = action;
				b.guest_addr  = guest_addr;
				b.access_kind = access_kind;
				b.read_data   = read_data;
				b.read_error  = read_error;
				if (walk_step(b, r))
					pending_results.push_back(drv_chk ? drv_want : r);
			end
		end
	end

	task automatic chk(input string what, input logic [63:0] e, input logic [63:0] a);
		if (e !== a) begin
			errs++;
			if (errs <= 10)
				$display("%0t: %0s mismatch: expected %h, got %h", $time, what, e, a);
		end
	endtask

	always @(posedge clk) begin
		xlat_t w;
		if (arst_n && out_valid && !out_stall) begin
			n_results++;
			if (pending_results.size() == 0) begin
				errs++;
				if (errs <= 10)
					$display("%0t: result with none expected, kind %0d", $time, kind);
			end else begin
				w = pending_results.pop_front();
				chk("kind", 64'(w.kind), 64'(kind));
				chk("read_address", 64'(w.rd_addr), 64'(read_address));
				chk("translated_addr", 64'(w.xaddr), 64'(translated_addr));
				chk("permissions", 64'(w.perms), 64'(permissions));
				chk("fault_info", 64'(w.finfo), 64'(fault_info));
				if (w.kind == nptw_pkg::KIND_DONE)
					n_done++;
				if (w.kind == nptw_pkg::KIND_FAULT)
					n_fault++;
			end
		end
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < rx_pct);
	end

	function automatic xlat_t res(input nptw_pkg::kind_t k,
		input logic [nptw_pkg::AddrW-1:0] rd, input logic [nptw_pkg::AddrW-1:0] xa,
		input logic [2:0] pm, input logic [nptw_pkg::FaultW-1:0] fi);
		xlat_t r;
		r.kind = k;
		r.rd_addr = rd;
		r.xaddr = xa;
		r.perms = pm;
		r.finfo = fi;
		return r;
	endfunction

	function automatic row_t mk(input logic act, input logic [nptw_pkg::AddrW-1:0] ga,
		input logic [1:0] acc, input logic [nptw_pkg::PteW-1:0] pte, input logic err,
		input bit c = 1'b0, input xlat_t w = '0);
		row_t rw;
		rw.it.action      = act;
		rw.it.guest_addr  = ga;
		rw.it.access_kind = acc;
		rw.it.read_data   = pte;
		rw.it.read_error  = err;
		rw.chk  = c;
		rw.want = w;
		return rw;
	endfunction

	function automatic logic [nptw_pkg::PteW-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic send(input row_t rw);
		while ($urandom_range(0, 99) < tx_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		action      <= rw.it.action;
		guest_addr  <= rw.it.guest_addr;
		access_kind <= rw.it.access_kind;
		read_data   <= rw.it.read_data;
		read_error  <= rw.it.read_error;
		drv_chk     <= rw.chk;
		drv_want    <= rw.want;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_root(input logic [nptw_pkg::AddrW-1:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic random_walk();
		logic [nptw_pkg::PteW-1:0] pte;
		logic err;
		int lv;
		send(mk(nptw_pkg::ACT_START, 52'(rand64()), 2'($urandom_range(0, 3)), rand64(),
			1'($urandom_range(0, 1))));
		n_items++;
		walk_open = 1'b1;
		lv = 4;
		while (walk_open) begin
			if ($urandom_range(0, 99) < 4)
				break;
			pte = rand64();
			if ($urandom_range(0, 99) < 93) begin
				pte[nptw_pkg::PTE_V] = 1'b1;
				pte[nptw_pkg::PTE_U] = 1'b1;
			end
			pte[nptw_pkg::PTE_RW] = ($urandom_range(0, 99) < 85);
			pte[nptw_pkg::PTE_NX] = ($urandom_range(0, 99) < 15);
			if (lv == 3 || lv == 2)
				pte[nptw_pkg::PTE_PS] = ($urandom_range(0, 99) < 25);
			err = ($urandom_range(0, 99) < 3);
			send(mk(nptw_pkg::ACT_RESP, 52'(rand64()), 2'($urandom_range(0, 3)), pte,
				err));
			n_items++;
			if (err || !pte[nptw_pkg::PTE_V] || !pte[nptw_pkg::PTE_U] || lv == 1 ||
				((lv == 3 || lv == 2) && pte[nptw_pkg::PTE_PS]))
				walk_open = 1'b0;
			lv--;
		end
	endtask

	initial begin
		logic [nptw_pkg::AddrW-1:0] root;
		int unsigned goal;

		// reset root pointer is zero; directed walks run against it
		dir_rows.push_back(mk(nptw_pkg::ACT_START, 52'h0, ACC_READ, 64'h0, 1'b0, 1'b1,
			res(nptw_pkg::KIND_READ, 52'h0, 52'h0, 3'd0, 33'h0)));
		dir_rows.push_back(mk(nptw_pkg::ACT_RESP, 52'h0, ACC_READ, 64'h7, 1'b0));
		dir_rows.push_back(mk(nptw_pkg::ACT_RESP, 52'h0, ACC_READ, 64'h7, 1'b0));
		dir_rows.push_back(mk(nptw_pkg::ACT_RESP, 52'h0, ACC_READ, 64'h7, 1'b0));
		dir_rows.push_back(mk(nptw_pkg::ACT_RESP, 52'h0, ACC_READ,
			64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1,
			res(nptw_pkg::KIND_DONE, 52'h0, 52'hF_FFFF_FFFF_F000,
			nptw_pkg::R_READ | nptw_pkg::R_WRITE, 33'h0)));
		// stray response, walker idle
		dir_rows.push_back(mk(nptw_pkg::ACT_RESP, 52'h0, ACC_READ, 64'h7, 1'b0));
		dir_rows.push_back(mk(nptw_pkg::ACT_START, 52'hF_FFFF_FFFF_FFFF,
			nptw_pkg::ACC_WRITE, 64'h0, 1'b0, 1'b1,
			res(nptw_pkg::KIND_READ, 52'hFF8, 52'h0, 3'd0, 33'h0)));
		dir_rows.push_back(mk(nptw_pkg::ACT_RESP, 52'h0, ACC_READ,
			64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1,
			res(nptw_pkg::KIND_FAULT, 52'h0, 52'h0, 3'd0, 33'h1_0000_0006)));
		dir_rows.push_back(mk(nptw_pkg::ACT_START, 52'hF_FFFF_FFFF_FFFF,
			nptw_pkg::ACC_EXEC, 64'h0, 1'b0));
		dir_rows.push_back(mk(nptw_pkg::ACT_RESP, 52'h0, ACC_READ, 64'h7, 1'b0));
		// 1G page at level 3
		dir_rows.push_back(mk(nptw_pkg::ACT_RESP, 52'h0, ACC_READ,
			64'h000F_FFFF_C000_0087, 1'b0, 1'b1,
			res(nptw_pkg::KIND_DONE, 52'h0, 52'hF_FFFF_FFFF_FFFF, nptw_pkg::R_ALL,
			33'h0)));
		dir_rows.push_back(mk(nptw_pkg::ACT_START, 52'h0_1234_5678_9ABC,
			nptw_pkg::ACC_WRITE, 64'h0, 1'b0));
		dir_rows.push_back(mk(nptw_pkg::ACT_RESP, 52'h0, ACC_READ, 64'h5, 1'b0));
		dir_rows.push_back(mk(nptw_pkg::ACT_RESP, 52'h0, ACC_READ, 64'h5, 1'b0));
		// 2M page, write right lost on the way
		dir_rows.push_back(mk(nptw_pkg::ACT_RESP, 52'h0, ACC_READ,
			64'h0000_0000_0020_0085, 1'b0, 1'b1,
			res(nptw_pkg::KIND_FAULT, 52'h0, 52'h0, 3'd0, 33'h1_0000_0007)));
		dir_rows.push_back(mk(nptw_pkg::ACT_START, 52'hA_5A5A_5A5A_5A5A, ACC_RSVD,
			64'h0, 1'b0));
		dir_rows.push_back(mk(nptw_pkg::ACT_RESP, 52'h0, ACC_READ, 64'h6, 1'b0, 1'b1,
			res(nptw_pkg::KIND_FAULT, 52'h0, 52'h0, 3'd0, 33'h1_0000_0004)));
		dir_rows.push_back(mk(nptw_pkg::ACT_START, 52'h5_A5A5_A5A5_A5A5,
			nptw_pkg::ACC_EXEC, 64'h0, 1'b0));
		dir_rows.push_back(mk(nptw_pkg::ACT_RESP, 52'h0, ACC_READ, 64'h3, 1'b0, 1'b1,
			res(nptw_pkg::KIND_FAULT, 52'h0, 52'h0, 3'd0, 33'h1_0000_0014)));
		// restart abandons the walk in flight
		dir_rows.push_back(mk(nptw_pkg::ACT_START, 52'h0_0000_DEAD_B000,
			nptw_pkg::ACC_EXEC, 64'h0, 1'b0));
		dir_rows.push_back(mk(nptw_pkg::ACT_START, 52'h0_0000_0000_1FFF, ACC_READ,
			64'h0, 1'b0));
		dir_rows.push_back(mk(nptw_pkg::ACT_RESP, 52'h0, ACC_READ,
			64'h8000_0000_0000_0087, 1'b0));
		dir_rows.push_back(mk(nptw_pkg::ACT_RESP, 52'h0, ACC_READ, 64'h7, 1'b0));
		dir_rows.push_back(mk(nptw_pkg::ACT_RESP, 52'h0, ACC_READ, 64'h7, 1'b0));
		dir_rows.push_back(mk(nptw_pkg::ACT_RESP, 52'h0, ACC_READ, 64'h87, 1'b0));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			send(dir_rows[i]);
			n_items++;
		end

		for (int p = 0; p < 4; p++) begin
			drain();
			case (p)
				0: root = 52'hF_FFFF_FFFF_FFFF;
				1: root = 52'(rand64());
				2: root = 52'h0;
				default: root = 52'(rand64()) | 52'hFFF;
			endcase
			write_root(root);
			tx_pct = (p == 1) ? 46 : (p == 3) ? 25 : 0;
			rx_pct = (p == 2) ? 46 : (p == 3) ? 25 : 0;
			goal = n_items + PHASE_BEATS;
			while (n_items < goal) begin
				if (!walk_open && $urandom_range(0, 99) < 8)
					send(mk(nptw_pkg::ACT_RESP, 52'(rand64()), 2'($urandom_range(0, 3)),
						rand64(), 1'($urandom_range(0, 1))));
				else
					random_walk();
			end
			if (walk_open) begin
				send(mk(nptw_pkg::ACT_RESP, 52'(rand64()), ACC_READ, rand64(), 1'b1));
				n_items++;
				walk_open = 1'b0;
			end
		end
		drain();
		rx_pct = 0;

		$display("walks: %0d beats accepted, %0d results checked (%0d translations, %0d faults)",
			n_beats, n_results, n_done, n_fault);
		$display("four root pointers, sender gaps and receiver stalls; %0d mismatches", errs);
		if (errs == 0 && pending_results.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> nested_page_table_walker_core.f
hw/rtl/nptw_pkg.sv
hw/rtl/nptw_step.sv
hw/rtl/nested_page_table_walker_core.sv
verif/tb.sv
